>>> src/assert_macros.svh
// Assertion macros shared by the recognizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define TDFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define TDFA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> src/tdfa_pkg.sv
// Types and constants shared by the table-driven automaton modules.
package tdfa_pkg;

  localparam int REQ_W   = 3;
  localparam int CODE_W  = 8;
  localparam int SYM_W   = 4;
  localparam int STATE_W = 4;
  localparam int ENTRY_W = 5;
  localparam int CALC_W  = 9;

  localparam logic [REQ_W-1:0] REQ_MAP   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_TRANS = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FINAL = 3'd2;
  localparam logic [REQ_W-1:0] REQ_FEED  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_END   = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [CODE_W-1:0]  symbol_code;
    logic [SYM_W-1:0]   symbol_index;
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic               entry_present;
  } tdfa_in_t;

  typedef struct packed {
    logic               accepted;
    logic [STATE_W-1:0] end_state;
  } tdfa_out_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [STATE_W-1:0] from_state;
    logic               entry_present;
    logic               feed_ok;
  } tdfa_s3_t;

  typedef struct packed {
    logic ready;
    logic hold_state;
  } tdfa_exec_st_t;

endpackage

>>> src/tdfa_mem.sv
// Single-port table memory with a registered read.
module tdfa_mem import tdfa_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic               clk,
  input  logic               we,
  input  logic               re,
  input  logic [AW-1:0]      addr,
  input  logic [ENTRY_W-1:0] wdata,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem_r [DEPTH];
  logic [ENTRY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/tdfa_clear.sv
// Post-reset sweep counter that clears the table memories.
module tdfa_clear #(
  parameter int DEPTH = 256,
  parameter int CW    = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  output logic          active,
  output logic [CW-1:0] idx
);

  logic          active_r;
  logic          active_nxt;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;

  always_comb begin
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    if (active_r) begin
      if (cnt_r == CW'(DEPTH - 1)) begin
        active_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b1;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign active = active_r;
  assign idx    = cnt_r;

endmodule

>>> src/tdfa_exec.sv
// Final stage: automaton state, final flags and the result register.
module tdfa_exec import tdfa_pkg::*; #(
  parameter int NUM_STATES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tdfa_s3_t           push_item,
  input  logic [ENTRY_W-1:0] tt_rdata,
  input  logic               cfg_we,
  input  logic [STATE_W-1:0] cfg_start,
  input  logic               out_ready,
  output tdfa_exec_st_t      status,
  output logic [STATE_W-1:0] cur_state,
  output logic               out_valid,
  output tdfa_out_t          out_word
);

`include "assert_macros.svh"

  localparam int ST_DEPTH = (NUM_STATES < (1 << STATE_W)) ? NUM_STATES : (1 << STATE_W);
  localparam int FF_AW    = $clog2(ST_DEPTH);

  logic               s3_valid_r, s3_valid_nxt;
  tdfa_s3_t           s3_item_r, s3_item_nxt;
  logic [STATE_W-1:0] start_r, start_nxt;
  logic [STATE_W-1:0] cur_r, cur_nxt;
  logic               dead_r, dead_nxt;
  logic [ST_DEPTH-1:0] final_r, final_nxt;
  logic               out_valid_r, out_valid_nxt;
  tdfa_out_t          out_word_r, out_word_nxt;

  logic is_end;
  logic adv;
  logic from_ok;
  logic cur_ok;
  logic final_hit;

  assign is_end    = s3_item_r.req_type == REQ_END;
  assign adv       = s3_valid_r && (!is_end || !out_valid_r || out_ready);
  assign from_ok   = CALC_W'(s3_item_r.from_state) < CALC_W'(NUM_STATES);
  assign cur_ok    = CALC_W'(cur_r) < CALC_W'(NUM_STATES);
  assign final_hit = cur_ok && final_r[cur_r[FF_AW-1:0]];

  always_comb begin
    s3_valid_nxt  = push ? 1'b1 : (adv ? 1'b0 : s3_valid_r);
    s3_item_nxt   = push ? push_item : s3_item_r;
    start_nxt     = start_r;
    cur_nxt       = cur_r;
    dead_nxt      = dead_r;
    final_nxt     = final_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    if (adv) begin
      case (s3_item_r.req_type)
        REQ_FINAL: begin
          if (from_ok) begin
            final_nxt[s3_item_r.from_state[FF_AW-1:0]] = s3_item_r.entry_present;
          end
        end
        REQ_FEED: begin
          if (!dead_r) begin
            if (!s3_item_r.feed_ok || !cur_ok || !tt_rdata[ENTRY_W-1]) begin
              dead_nxt = 1'b1;
            end else begin
              cur_nxt = tt_rdata[STATE_W-1:0];
            end
          end
        end
        REQ_END: begin
          out_valid_nxt          = 1'b1;
          out_word_nxt.accepted  = !dead_r && final_hit;
          out_word_nxt.end_state = cur_r;
          cur_nxt                = start_r;
          dead_nxt               = 1'b0;
        end
        default: begin
        end
      endcase
    end
    if (cfg_we) begin
      start_nxt = cfg_start;
      cur_nxt   = cfg_start;
      dead_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r  <= 1'b0;
      start_r     <= '0;
      cur_r       <= '0;
      dead_r      <= 1'b0;
      final_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s3_valid_r  <= s3_valid_nxt;
      start_r     <= start_nxt;
      cur_r       <= cur_nxt;
      dead_r      <= dead_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s3_item_r  <= s3_item_nxt;
    out_word_r <= out_word_nxt;
  end

  assign status.ready      = !s3_valid_r || adv;
  assign status.hold_state = s3_valid_r &&
                             (s3_item_r.req_type == REQ_FEED || is_end);
  assign cur_state = cur_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `TDFA_ASSERT(a_end_reports_state, (adv && is_end) |=> (out_valid_r && out_word_r.end_state == $past(cur_r)), "End of word did not report the held state.")
  `TDFA_ASSERT(a_dead_word_frozen, (adv && s3_item_r.req_type == REQ_FEED && dead_r && !cfg_we) |=> ($stable(cur_r) && dead_r), "A dead word changed state.")

endmodule

>>> src/table_driven_dfa_recognizer_top.sv
// Top level of the programmable table-driven automaton recognizer.
// An end-of-word result passes through the stage-2 and stage-3 registers into the result register.
// Table writes, flag writes and ends of word are taken one per cycle while the result output and the
// stages ahead do not stall; a fed character is held when it follows another character or an end of
// word, since the transition-memory read must finish before the next state is known.
// After reset a clearing pass sweeps max(CHAR_CODES, states * symbols) entries, 256 by default.
module table_driven_dfa_recognizer_top import tdfa_pkg::*; #(
  parameter int NUM_STATES    = 16,
  parameter int ALPHABET_SIZE = 16,
  parameter int CHAR_CODES    = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tdfa_in_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tdfa_out_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [STATE_W-1:0] cfg_data
);

`include "assert_macros.svh"

  localparam int ST_DEPTH  = (NUM_STATES < (1 << STATE_W)) ? NUM_STATES : (1 << STATE_W);
  localparam int AL_DEPTH  = (ALPHABET_SIZE < (1 << SYM_W)) ? ALPHABET_SIZE : (1 << SYM_W);
  localparam int TT_DEPTH  = ST_DEPTH * AL_DEPTH;
  localparam int TT_AW     = $clog2(TT_DEPTH);
  localparam int MAP_AW    = $clog2(CHAR_CODES);
  localparam int CLR_DEPTH = (CHAR_CODES > TT_DEPTH) ? CHAR_CODES : TT_DEPTH;
  localparam int CLR_CW    = $clog2(CLR_DEPTH);

  logic              clr_active;
  logic [CLR_CW-1:0] clr_idx;

  logic     accept;
  logic     code_ok;
  logic     s2_valid_r, s2_valid_nxt;
  tdfa_in_t s2_item_r, s2_item_nxt;
  logic     s2_code_ok_r, s2_code_ok_nxt;
  logic     s2_hold;
  logic     s2_adv;

  logic               map_we, map_re;
  logic [MAP_AW-1:0]  map_addr;
  logic [ENTRY_W-1:0] map_wdata, map_rdata;
  logic               map_valid;
  logic [SYM_W-1:0]   map_sym;

  logic               tt_we, tt_re;
  logic [TT_AW-1:0]   tt_addr;
  logic [ENTRY_W-1:0] tt_wdata, tt_rdata;
  logic [STATE_W-1:0] tt_row;
  logic [CALC_W-1:0]  tt_calc;

  tdfa_exec_st_t      exec_st;
  tdfa_s3_t           push_item;
  logic [STATE_W-1:0] cur_state;

  tdfa_clear #(
    .DEPTH (CLR_DEPTH),
    .CW    (CLR_CW)
  ) u_clear (
    .clk    (clk),
    .rst_n  (rst_n),
    .active (clr_active),
    .idx    (clr_idx)
  );

  assign accept  = in_valid && in_ready;
  assign code_ok = CALC_W'(in_data.symbol_code) < CALC_W'(CHAR_CODES);

  always_comb begin
    map_we    = 1'b0;
    map_wdata = '0;
    map_addr  = in_data.symbol_code[MAP_AW-1:0];
    map_re    = accept && in_data.req_type != REQ_MAP;
    if (clr_active) begin
      map_addr = clr_idx[MAP_AW-1:0];
      map_we   = CALC_W'(clr_idx) < CALC_W'(CHAR_CODES);
    end else if (accept && in_data.req_type == REQ_MAP && code_ok) begin
      if (!in_data.entry_present) begin
        map_we = 1'b1;
      end else if (CALC_W'(in_data.symbol_index) < CALC_W'(ALPHABET_SIZE)) begin
        map_we    = 1'b1;
        map_wdata = {1'b1, in_data.symbol_index};
      end
    end
  end

  tdfa_mem #(
    .DEPTH (CHAR_CODES),
    .AW    (MAP_AW)
  ) u_map_mem (
    .clk   (clk),
    .we    (map_we),
    .re    (map_re),
    .addr  (map_addr),
    .wdata (map_wdata),
    .rdata (map_rdata)
  );

  assign map_valid = map_rdata[ENTRY_W-1];
  assign map_sym   = map_rdata[SYM_W-1:0];

  assign s2_hold = s2_valid_r && s2_item_r.req_type == REQ_FEED && exec_st.hold_state;
  assign s2_adv  = s2_valid_r && !s2_hold && exec_st.ready;

  assign tt_row  = (s2_item_r.req_type == REQ_TRANS) ? s2_item_r.from_state : cur_state;
  assign tt_calc = CALC_W'(tt_row) * CALC_W'(AL_DEPTH) + CALC_W'(map_sym);
  assign tt_re   = s2_adv && s2_item_r.req_type == REQ_FEED;

  always_comb begin
    tt_we    = 1'b0;
    tt_wdata = '0;
    tt_addr  = tt_calc[TT_AW-1:0];
    if (clr_active) begin
      tt_addr = clr_idx[TT_AW-1:0];
      tt_we   = CALC_W'(clr_idx) < CALC_W'(TT_DEPTH);
    end else if (s2_adv && s2_item_r.req_type == REQ_TRANS && s2_code_ok_r && map_valid &&
                 CALC_W'(s2_item_r.from_state) < CALC_W'(NUM_STATES)) begin
      if (!s2_item_r.entry_present) begin
        tt_we = 1'b1;
      end else if (CALC_W'(s2_item_r.to_state) < CALC_W'(NUM_STATES)) begin
        tt_we    = 1'b1;
        tt_wdata = {1'b1, s2_item_r.to_state};
      end
    end
  end

  tdfa_mem #(
    .DEPTH (TT_DEPTH),
    .AW    (TT_AW)
  ) u_trans_mem (
    .clk   (clk),
    .we    (tt_we),
    .re    (tt_re),
    .addr  (tt_addr),
    .wdata (tt_wdata),
    .rdata (tt_rdata)
  );

  always_comb begin
    s2_valid_nxt   = accept ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_r);
    s2_item_nxt    = accept ? in_data : s2_item_r;
    s2_code_ok_nxt = accept ? code_ok : s2_code_ok_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s2_item_r    <= s2_item_nxt;
    s2_code_ok_r <= s2_code_ok_nxt;
  end

  assign push_item.req_type      = s2_item_r.req_type;
  assign push_item.from_state    = s2_item_r.from_state;
  assign push_item.entry_present = s2_item_r.entry_present;
  assign push_item.feed_ok       = s2_code_ok_r && map_valid;

  tdfa_exec #(
    .NUM_STATES (NUM_STATES)
  ) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_adv),
    .push_item (push_item),
    .tt_rdata  (tt_rdata),
    .cfg_we    (cfg_valid),
    .cfg_start (cfg_data),
    .out_ready (out_ready),
    .status    (exec_st),
    .cur_state (cur_state),
    .out_valid (out_valid),
    .out_word  (out_data)
  );

  assign in_ready  = !clr_active && (!s2_valid_r || s2_adv);
  assign cfg_ready = 1'b1;

  `TDFA_NEVER(a_no_accept_in_clear, clr_active && in_ready, "Input ready during table clearing.")
  `TDFA_ASSERT(a_feed_read_interlocks, tt_re |=> exec_st.hold_state, "Transition read not followed by a state interlock.")

endmodule

>>> bench/tb_table_driven_dfa_recognizer_top.sv
// Self-checking testbench for the table-driven automaton recognizer top level.
`timescale 1ns / 1ps

module tb_table_driven_dfa_recognizer_top;
  import tdfa_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 400;
  localparam int POOL_SIZE     = 8;
  localparam logic [REQ_W-1:0] REQ_TOP = '1;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  tdfa_in_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  tdfa_out_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [STATE_W-1:0] cfg_data = '0;

  table_driven_dfa_recognizer_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the automaton and its tables.
  logic [STATE_W-1:0] start_reg = '0;
  logic [STATE_W-1:0] cur_state = '0;
  bit                 word_dead;
  bit                 map_ok [256];
  logic [SYM_W-1:0]   map_sym [256];
  bit                 arc_ok [16][16];
  logic [STATE_W-1:0] arc_dest [16][16];
  bit                 is_final [16];

  tdfa_in_t  words_to_send [$];
  tdfa_out_t verdicts_due [$];
  logic [CODE_W-1:0] code_pool [POOL_SIZE];

  int  words_queued;
  int  words_taken;
  int  words_ended;
  int  words_accepted;
  int  cfg_writes;
  int  failures;
  int  cycle_count;
  int  holds_asked;
  int  holds_served;
  int  hold_left;
  bit  calm;
  bit  in_took;

  task automatic advance_automaton(input tdfa_in_t w);
    logic [SYM_W-1:0] sym;
    tdfa_out_t        v;
    sym = map_sym[w.symbol_code];
    case (w.req_type)
      REQ_MAP: begin
        map_ok[w.symbol_code] = w.entry_present;
        map_sym[w.symbol_code] = w.entry_present ? w.symbol_index : '0;
      end
      REQ_TRANS: begin
        if (map_ok[w.symbol_code]) begin
          arc_ok[w.from_state][sym] = w.entry_present;
          arc_dest[w.from_state][sym] = w.entry_present ? w.to_state : '0;
        end
      end
      REQ_FINAL: is_final[w.from_state] = w.entry_present;
      REQ_FEED: begin
        if (!word_dead) begin
          if (!map_ok[w.symbol_code] || !arc_ok[cur_state][sym]) begin
            word_dead = 1'b1;
          end else begin
            cur_state = arc_dest[cur_state][sym];
          end
        end
      end
      REQ_END: begin
        v.accepted = !word_dead && is_final[cur_state];
        v.end_state = cur_state;
        verdicts_due.push_back(v);
        words_ended++;
        if (v.accepted) words_accepted++;
        cur_state = start_reg;
        word_dead = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic check_verdict(input tdfa_out_t got);
    tdfa_out_t want;
    if (verdicts_due.size() == 0) begin
      $error("result with nothing expected: accepted %0d end_state %0d",
             got.accepted, got.end_state);
      failures++;
    end else begin
      want = verdicts_due.pop_front();
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
        failures++;
      end
      if (got.end_state !== want.end_state) begin
        $error("end_state: expected %0d, got %0d", want.end_state, got.end_state);
        failures++;
      end
    end
  endtask

  always @(posedge clk) begin
    in_took = rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        start_reg = cfg_data;
        cur_state = cfg_data;
        word_dead = 1'b0;
        cfg_writes++;
      end
      if (in_took) begin
        advance_automaton(in_data);
        words_taken++;
      end
      if (out_valid && out_ready) check_verdict(out_data);
    end
  end

  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (words_to_send.size() != 0 && (calm || $urandom_range(99) >= 14)) begin
        in_data <= words_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (holds_served != holds_asked) begin
      holds_served = holds_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || $urandom_range(99) >= 14;
    end
  end

  function automatic logic [STATE_W-1:0] pick_state();
    logic [31:0] r;
    r = $urandom;
    return (r[9:8] != 2'b00) ? {1'b0, r[2:0]} : r[3:0];
  endfunction

  function automatic logic [CODE_W-1:0] pool_code();
    return code_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  task automatic queue_word(input logic [REQ_W-1:0] req, input logic [CODE_W-1:0] code,
                            input logic [SYM_W-1:0] sidx, input logic [STATE_W-1:0] from,
                            input logic [STATE_W-1:0] to, input logic present);
    tdfa_in_t w;
    w.req_type = req;
    w.symbol_code = code;
    w.symbol_index = sidx;
    w.from_state = from;
    w.to_state = to;
    w.entry_present = present;
    words_to_send.push_back(w);
    words_queued++;
  endtask

  task automatic random_items(input int count);
    tdfa_in_t    w;
    int unsigned pick;
    logic [31:0] r;
    for (int i = 0; i < count; i++) begin
      r = $urandom;
      w = r[$bits(tdfa_in_t)-1:0];
      pick = $urandom_range(99);
      if (pick < 8) begin
        w.req_type = REQ_MAP;
        w.symbol_code = pool_code();
        w.entry_present = $urandom_range(99) < 85;
      end else if (pick < 20) begin
        w.req_type = REQ_TRANS;
        w.symbol_code = pool_code();
        w.from_state = pick_state();
        w.to_state = pick_state();
        w.entry_present = $urandom_range(99) < 85;
      end else if (pick < 26) begin
        w.req_type = REQ_FINAL;
        w.from_state = pick_state();
      end else if (pick < 76) begin
        w.req_type = REQ_FEED;
        w.symbol_code = pool_code();
      end else if (pick < 94) begin
        w.req_type = REQ_END;
      end else if (pick < 97) begin
        w.req_type = REQ_FEED;
      end else begin
        w.req_type = REQ_END + REQ_W'($urandom_range(1, REQ_TOP - REQ_END));
      end
      words_to_send.push_back(w);
      words_queued++;
    end
  endtask

  task automatic settle();
    while (words_taken != words_queued || verdicts_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_start(input logic [STATE_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("tb_table_driven_dfa_recognizer_top failed");
    $finish;
  end

  initial begin
    logic [31:0] r;
    code_pool[0] = 8'h00;
    code_pool[1] = 8'hFF;
    for (int i = 2; i < POOL_SIZE; i++) begin
      r = $urandom;
      code_pool[i] = r[CODE_W-1:0];
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_start(4'd0);
    queue_word(REQ_END,   8'h00, 4'h0, 4'h0, 4'h0, 1'b0);
    queue_word(REQ_FEED,  8'hFF, 4'hF, 4'hF, 4'hF, 1'b1);
    queue_word(REQ_END,   8'hFF, 4'hF, 4'hF, 4'hF, 1'b1);
    queue_word(REQ_MAP,   8'h00, 4'h0, 4'h0, 4'h0, 1'b1);
    queue_word(REQ_MAP,   8'hFF, 4'hF, 4'hF, 4'hF, 1'b1);
    queue_word(REQ_MAP,   8'hAA, 4'h5, 4'h0, 4'h0, 1'b1);
    queue_word(REQ_MAP,   8'hAA, 4'hF, 4'h0, 4'h0, 1'b0);
    queue_word(REQ_TRANS, 8'hAA, 4'h0, 4'h0, 4'h9, 1'b1);
    queue_word(REQ_TRANS, 8'h00, 4'h0, 4'h0, 4'hF, 1'b1);
    queue_word(REQ_TRANS, 8'hFF, 4'h0, 4'hF, 4'h0, 1'b1);
    queue_word(REQ_FINAL, 8'h00, 4'h0, 4'hF, 4'h0, 1'b1);
    queue_word(REQ_FEED,  8'h00, 4'h0, 4'h0, 4'h0, 1'b0);
    queue_word(REQ_END,   8'h00, 4'h0, 4'h0, 4'h0, 1'b0);
    queue_word(REQ_FEED,  8'h00, 4'h0, 4'h0, 4'h0, 1'b0);
    queue_word(REQ_FEED,  8'hFF, 4'h0, 4'h0, 4'h0, 1'b0);
    queue_word(REQ_FEED,  8'h00, 4'h0, 4'h0, 4'h0, 1'b0);
    queue_word(REQ_END,   8'h00, 4'h0, 4'h0, 4'h0, 1'b0);
    queue_word(REQ_FEED,  8'h00, 4'h0, 4'h0, 4'h0, 1'b0);
    queue_word(REQ_FEED,  8'h00, 4'h0, 4'h0, 4'h0, 1'b0);
    queue_word(REQ_FEED,  8'hFF, 4'h0, 4'h0, 4'h0, 1'b0);
    queue_word(REQ_END,   8'h00, 4'h0, 4'h0, 4'h0, 1'b0);
    queue_word(REQ_TRANS, 8'h00, 4'hF, 4'h0, 4'hF, 1'b0);
    queue_word(REQ_FEED,  8'h00, 4'h0, 4'h0, 4'h0, 1'b0);
    queue_word(REQ_END,   8'h00, 4'h0, 4'h0, 4'h0, 1'b0);
    queue_word(REQ_FINAL, 8'h00, 4'h0, 4'hF, 4'h0, 1'b0);
    for (int k = REQ_END + 1; k <= REQ_TOP; k++) begin
      queue_word(REQ_W'(k), 8'h5A, 4'hA, 4'h5, 4'hA, 1'b1);
    end
    settle();

    write_start(4'hF);
    random_items(200);
    settle();

    write_start(pick_state());
    calm = 1'b1;
    random_items(250);
    settle();
    calm = 1'b0;

    // The receiver holds off while words keep coming, so the result path backs up.
    holds_asked++;
    random_items(200);
    settle();

    write_start(4'd0);
    random_items(350);
    settle();

    write_start(pick_state());
    random_items(350);
    settle();

    $display("Run covered %0d input words and %0d start-state writes.", words_taken,
             cfg_writes);
    $display("Words ended: %0d, of which %0d were accepted.", words_ended, words_accepted);
    if (failures == 0) begin
      $display("tb_table_driven_dfa_recognizer_top passed");
    end else begin
      $display("tb_table_driven_dfa_recognizer_top failed");
    end
    $finish;
  end

endmodule
